[rtl/bld_pkg.sv]
`timescale 1ns / 1ps
// bld_pkg: word types, register map and constants of the breathing lock detector
// no dependencies

package bld_pkg;

  localparam int unsigned BIN_COUNT = 8;

  localparam logic [15:0] RUN_MAX         = 16'hffff;
  localparam logic [4:0]  REEMIT_LAST     = 5'd29;
  localparam logic [7:0]  DISMISS_CEILING = 8'd100;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd30;
  localparam logic [7:0]  WINDOW_RESET    = 8'd20;
  localparam logic [4:0]  RATE_BASE       = 5'd6;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_DISMISS = 1'b1;

  localparam logic EVT_CONFIRMED = 1'b0;
  localparam logic EVT_LOST      = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [7:0] bin0;
    logic signed [7:0] bin1;
    logic signed [7:0] bin2;
    logic signed [7:0] bin3;
    logic signed [7:0] bin4;
    logic signed [7:0] bin5;
    logic signed [7:0] bin6;
    logic signed [7:0] bin7;
  } bld_in_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] peak_magnitude;
    logic [2:0] peak_index;
    logic [4:0] rate_bpm;
  } bld_out_t;

  typedef struct packed {
    logic       is_dismiss;
    logic       avg_ok;
    logic [7:0] peak_mag;
    logic [2:0] peak_idx;
  } bld_cmd_t;

  typedef struct packed {
    logic       thr_load;
    logic [7:0] thr_value;
    logic [7:0] window;
  } bld_cfg_t;

endpackage

[rtl/bld_fifo.sv]
`timescale 1ns / 1ps
// bld_fifo: small register queue with registered storage
// no dependencies

module bld_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[rtl/bld_front.sv]
`timescale 1ns / 1ps
// bld_front: classifies an input word into peak bin, index and average test
// depends on bld_pkg

module bld_front (
  input  bld_pkg::bld_in_t  in_i,
  output bld_pkg::bld_cmd_t cmd_o
);

  logic [7:0]  raw  [bld_pkg::BIN_COUNT];
  logic [7:0]  mag  [bld_pkg::BIN_COUNT];
  logic [7:0]  best;
  logic [2:0]  best_idx;
  logic [10:0] sum;
  logic [7:0]  avg;
  logic [8:0]  floor15;

  assign raw[0] = in_i.bin0;
  assign raw[1] = in_i.bin1;
  assign raw[2] = in_i.bin2;
  assign raw[3] = in_i.bin3;
  assign raw[4] = in_i.bin4;
  assign raw[5] = in_i.bin5;
  assign raw[6] = in_i.bin6;
  assign raw[7] = in_i.bin7;

  always_comb begin
    for (int i = 0; i < bld_pkg::BIN_COUNT; i++) begin
      mag[i] = raw[i][7] ? (~raw[i] + 8'd1) : raw[i];
    end
  end

  // first largest wins
  always_comb begin
    best     = '0;
    best_idx = '0;
    sum      = '0;
    for (int i = 0; i < bld_pkg::BIN_COUNT; i++) begin
      sum = sum + {3'b000, mag[i]};
      if (mag[i] > best) begin
        best     = mag[i];
        best_idx = 3'(i);
      end
    end
  end

  assign avg     = sum[10:3];
  assign floor15 = {1'b0, avg} + {2'b00, avg[7:1]};

  assign cmd_o.is_dismiss = (in_i.req_type == bld_pkg::REQ_DISMISS);
  assign cmd_o.avg_ok     = ({1'b0, best} >= floor15);
  assign cmd_o.peak_mag   = best;
  assign cmd_o.peak_idx   = best_idx;

endmodule

[rtl/bld_back.sv]
`timescale 1ns / 1ps
// bld_back: lock counter, confirm flag and working threshold; builds result words
// depends on bld_pkg

module bld_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bld_pkg::bld_cfg_t cfg_i,
  input  bld_pkg::bld_cmd_t cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic              out_room_i,
  output logic              out_push_o,
  output bld_pkg::bld_out_t out_data_o
);

  logic [15:0] lock_run_q, lock_run_d, run_inc;
  logic [4:0]  phase_q, phase_d, phase_inc;
  logic        conf_q, conf_d;
  logic [7:0]  wth_q, wth_d;
  logic        go, locked, emit, lost_word;

  assign go        = cmd_valid_i && out_room_i;
  assign cmd_pop_o = go;
  assign locked    = !cmd_i.is_dismiss && cmd_i.avg_ok && (cmd_i.peak_mag >= wth_q);

  // phase tracks the run count modulo the repeat period
  always_comb begin
    if (lock_run_q == bld_pkg::RUN_MAX) begin
      run_inc   = lock_run_q;
      phase_inc = phase_q;
    end else begin
      run_inc   = lock_run_q + 16'd1;
      phase_inc = (phase_q == bld_pkg::REEMIT_LAST) ? 5'd0 : phase_q + 5'd1;
    end
  end

  always_comb begin
    lock_run_d = lock_run_q;
    phase_d    = phase_q;
    conf_d     = conf_q;
    wth_d      = wth_q;
    emit       = 1'b0;
    lost_word  = 1'b0;
    if (go) begin
      if (cmd_i.is_dismiss) begin
        if (wth_q < bld_pkg::DISMISS_CEILING) begin
          wth_d = wth_q + 8'd1;
        end
      end else if (locked) begin
        lock_run_d = run_inc;
        phase_d    = phase_inc;
        if (!conf_q && (run_inc >= {8'd0, cfg_i.window})) begin
          conf_d = 1'b1;
          emit   = 1'b1;
        end else if (conf_q && (phase_inc == 5'd0)) begin
          emit = 1'b1;
        end
      end else begin
        lock_run_d = '0;
        phase_d    = '0;
        if (conf_q) begin
          conf_d    = 1'b0;
          emit      = 1'b1;
          lost_word = 1'b1;
        end
      end
    end
    if (cfg_i.thr_load) begin
      wth_d = cfg_i.thr_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_run_q <= '0;
      phase_q    <= '0;
      conf_q     <= 1'b0;
      wth_q      <= bld_pkg::THRESHOLD_RESET;
    end else begin
      lock_run_q <= lock_run_d;
      phase_q    <= phase_d;
      conf_q     <= conf_d;
      wth_q      <= wth_d;
    end
  end

  assign out_push_o = emit;

  always_comb begin
    if (lost_word) begin
      out_data_o.event_kind     = bld_pkg::EVT_LOST;
      out_data_o.peak_magnitude = '0;
      out_data_o.peak_index     = '0;
      out_data_o.rate_bpm       = '0;
    end else begin
      out_data_o.event_kind     = bld_pkg::EVT_CONFIRMED;
      out_data_o.peak_magnitude = cmd_i.peak_mag;
      out_data_o.peak_index     = cmd_i.peak_idx;
      out_data_o.rate_bpm       = bld_pkg::RATE_BASE + {2'b00, cmd_i.peak_idx}
                                  + {1'b0, cmd_i.peak_idx, 1'b0};
    end
  end

  a_lost_needs_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_data_o.event_kind == bld_pkg::EVT_LOST) |-> conf_q)
    else $error("lost word without confirmation");

  a_conf_rise_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(conf_q) |-> $past(out_push_o))
    else $error("confirmation without word");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= bld_pkg::REEMIT_LAST)
    else $error("phase out of range");

  a_phase_tracks_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_run_q == 16'd0) |-> (phase_q == 5'd0))
    else $error("phase not cleared with run");

endmodule

[rtl/breathing_lock_detector_unit.sv]
`timescale 1ns / 1ps
// breathing_lock_detector_unit: top level with register port, front, back and queues
// depends on bld_pkg, bld_front, bld_back, bld_fifo
//
// input channel: a word is taken when push is high and full is low; a tick
// word carries eight signed bins, a dismiss word raises the working threshold.
// result channel: the oldest result word is on out_data_o while empty is low
// and leaves when pop is high. a word gives zero or one result.
// path: a word goes through the command queue, the back and the result queue.
// throughput: one word per cycle while the result queue has room, set by the
// back state update; the front classifies all eight bins combinationally.
// register port: reg 0 at 0x0 is the start threshold (writing it loads the
// working threshold), reg 1 at 0x4 is the confirm window. write only while idle.
// reset: threshold 30, window 20, lock count and confirm flag cleared, queues empty.
// stall: when pop stays low the result queue fills, the back stops, the
// command queue fills and full rises; nothing is dropped.

module breathing_lock_detector_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  bld_pkg::bld_in_t   in_data_i,
  output logic               empty,
  input  logic               pop,
  output bld_pkg::bld_out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CmdW = $bits(bld_pkg::bld_cmd_t);
  localparam int unsigned OutW = $bits(bld_pkg::bld_out_t);

  logic [7:0]        thr_start_q, window_q;
  logic              wr_en;
  bld_pkg::bld_cfg_t cfg;
  bld_pkg::bld_cmd_t front_cmd, back_cmd;
  logic [CmdW-1:0]   cmd_raw;
  logic [OutW-1:0]   out_raw;
  bld_pkg::bld_out_t back_out;
  logic              cmd_empty, cmd_pop, out_full, out_push;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_start_q <= bld_pkg::THRESHOLD_RESET;
      window_q    <= bld_pkg::WINDOW_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        bld_pkg::REG_THRESHOLD: thr_start_q <= pwdata[7:0];
        bld_pkg::REG_WINDOW:    window_q    <= pwdata[7:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bld_pkg::REG_THRESHOLD: prdata = {24'd0, thr_start_q};
      bld_pkg::REG_WINDOW:    prdata = {24'd0, window_q};
      default:                prdata = '0;
    endcase
  end

  assign cfg.thr_load  = wr_en && (paddr[2] == bld_pkg::REG_THRESHOLD);
  assign cfg.thr_value = pwdata[7:0];
  assign cfg.window    = window_q;

  bld_front u_front (
    .in_i  (in_data_i),
    .cmd_o (front_cmd)
  );

  bld_fifo #(
    .WIDTH (CmdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty)
  );

  assign back_cmd = bld_pkg::bld_cmd_t'(cmd_raw);

  bld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_room_i  (!out_full),
    .out_push_o  (out_push),
    .out_data_o  (back_out)
  );

  bld_fifo #(
    .WIDTH (OutW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_out),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign out_data_o = bld_pkg::bld_out_t'(out_raw);

endmodule
